FILE: design/resource_quota_allocator_unit_assert.svh
// Assertion macros shared by the resource quota allocator RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef RESOURCE_QUOTA_ALLOCATOR_UNIT_ASSERT_SVH
`define RESOURCE_QUOTA_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RQA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rqa assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RQA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rqa assertion failed");

`endif

FILE: design/rqa_pkg.sv
// Package for the resource quota allocator: payload structs, codes, constants.
// Used by rqa_ctrl, rqa_dpath and resource_quota_allocator_unit; no dependencies.
`default_nettype none
package rqa_pkg;

    localparam int DEF_REQUESTERS = 64;
    localparam int DEF_POOLS      = 5;

    localparam int NUM_CAP_REGS = 5;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int THR_W        = 16;
    localparam int AMT_W        = 32;
    localparam int SUM_W        = 56;
    localparam int PROD_W       = AMT_W + THR_W;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd5;

    localparam logic [AMT_W-1:0] CAP_RESET [NUM_CAP_REGS] =
        '{32'd25600, 32'd268435456, 32'd256, 32'd25600, 32'd25600};
    localparam logic [THR_W-1:0] THR_RESET = 16'd55706;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;

    typedef struct packed {
        logic [1:0]       op;
        logic [2:0]       resource_kind;
        logic [5:0]       requester;
        logic [AMT_W-1:0] request_amount;
        logic             critical;
    } in_item_t;

    typedef struct packed {
        logic [AMT_W-1:0] granted;
        logic             whole_grant;
        logic             rejected;
        logic             alert_flag;
        logic [AMT_W-1:0] available_now;
        logic [AMT_W-1:0] usage_now;
        logic [AMT_W-1:0] peak_seen;
        logic [SUM_W-1:0] usage_total;
        logic [AMT_W-1:0] samples_seen;
        logic [AMT_W-1:0] grants_seen;
        logic [AMT_W-1:0] refusals_seen;
    } out_item_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic calc;
        logic fin;
    } rqa_cmd_t;

    typedef struct packed {
        logic clear_last;
    } rqa_stat_t;

endpackage
`default_nettype wire

FILE: design/rqa_ctrl.sv
// Controller state machine of the resource quota allocator.
// Depends on rqa_pkg and resource_quota_allocator_unit_assert.svh.
`default_nettype none
`include "resource_quota_allocator_unit_assert.svh"
module rqa_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire rqa_pkg::rqa_stat_t stat,
    output rqa_pkg::rqa_cmd_t      cmd
);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_CALC, S_FIN} state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd.clear = (state_reg == S_CLEAR);
        cmd.load  = (state_reg == S_IDLE) && in_valid;
        cmd.calc  = (state_reg == S_CALC);
        cmd.fin   = (state_reg == S_FIN) && slot_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (stat.clear_last) state_next = S_IDLE;
            S_IDLE:  if (in_valid) state_next = S_CALC;
            S_CALC:  state_next = S_FIN;
            S_FIN:   if (slot_free) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
        out_valid_next = cmd.fin ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    `RQA_ASSERT_NEXT(a_load_to_calc, cmd.load, state_reg == S_CALC)
    `RQA_ASSERT_NOW(a_fin_slot_free, cmd.fin, !out_valid_reg || !out_stall)
    `RQA_ASSERT_NEXT(a_fin_sets_valid, cmd.fin, out_valid_reg)
    `RQA_ASSERT_NOW(a_clear_blocks_input, state_reg == S_CLEAR, in_stall && !cmd.load)

endmodule
`default_nettype wire

FILE: design/rqa_dpath.sv
// Datapath of the resource quota allocator: configuration, pool statistics,
// holdings memory and result register. Depends on rqa_pkg.
`default_nettype none
module rqa_dpath #(
    parameter int REQUESTERS = rqa_pkg::DEF_REQUESTERS,
    parameter int POOLS      = rqa_pkg::DEF_POOLS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [rqa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rqa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire rqa_pkg::in_item_t                 in_item,
    output rqa_pkg::out_item_t                     out_item,
    input  wire rqa_pkg::rqa_cmd_t                 cmd,
    output rqa_pkg::rqa_stat_t                     stat
);

    localparam int DEPTH = REQUESTERS * POOLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = (POOLS > 1) ? $clog2(POOLS) : 1;
    localparam int W     = rqa_pkg::AMT_W;
    localparam int SW    = rqa_pkg::SUM_W;
    localparam int PRW   = rqa_pkg::PROD_W;
    localparam logic [W-1:0]  MAX32 = '1;
    localparam logic [SW-1:0] MAX56 = '1;

    // Configuration registers.
    logic [W-1:0]              cap_reg [rqa_pkg::NUM_CAP_REGS];
    logic [rqa_pkg::THR_W-1:0] thr_reg;

    // Per-pool state.
    logic [W-1:0]  usage_reg   [POOLS];
    logic [W-1:0]  peak_reg    [POOLS];
    logic [SW-1:0] sum_reg     [POOLS];
    logic [W-1:0]  samples_reg [POOLS];
    logic [W-1:0]  grants_reg  [POOLS];
    logic [W-1:0]  refusals_reg[POOLS];
    logic          alert_reg   [POOLS];

    // Holdings memory and its clearing counter.
    logic [W-1:0]  held_mem [DEPTH];
    logic [W-1:0]  held_rd_reg;
    logic [AW-1:0] clr_addr_reg;

    // Item registers.
    logic [1:0]    op_reg;
    logic [PW-1:0] pool_reg;
    logic [AW-1:0] addr_reg;
    logic [W-1:0]  amt_reg;
    logic          crit_reg;
    logic          inrange_reg;
    logic [PRW-1:0] prod_reg;

    // Results of the update step.
    logic [W-1:0]  granted_reg;
    logic          full_reg;
    logic          rej_reg;
    logic          stat_upd_reg;
    logic          eval_reg;

    logic [PW-1:0] in_pool;
    logic          in_range;
    logic [AW-1:0] in_addr;
    logic [W-1:0]  in_cap;

    logic [W-1:0]  cap_cur;
    logic [W-1:0]  use_cur;
    logic [W-1:0]  avail_cur;
    logic [W-1:0]  grant_amt;
    logic          alloc_ok;
    logic          alloc_full;
    logic [W:0]    nu_wide;
    logic [W-1:0]  nu_sat;
    logic [W:0]    nh_wide;
    logic [W-1:0]  nh_sat;
    logic [W-1:0]  rel_amt;
    logic [W-1:0]  use_rel;
    logic [W-1:0]  held_new;
    logic          is_alloc;
    logic          is_release;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [W-1:0]  mem_wdata;

    logic [W-1:0]  fin_use;
    logic [W-1:0]  fin_cap;
    logic          alert_new;
    logic [SW:0]   sum_wide;
    logic [SW-1:0] sum_new;
    logic [W-1:0]  peak_new;
    rqa_pkg::out_item_t out_next;

    function automatic logic [W-1:0] cap_of(input logic [PW-1:0] p,
                                            input logic [W-1:0] caps [rqa_pkg::NUM_CAP_REGS]);
        logic [W-1:0] c;
        c = '0;
        for (int i = 0; i < rqa_pkg::NUM_CAP_REGS; i++)
        begin
            if (32'(p) == 32'(i))
                c = caps[i];
        end
        return c;
    endfunction

    // Item capture.
    assign in_pool  = PW'(in_item.resource_kind);
    assign in_range = (32'(in_item.resource_kind) < 32'(POOLS))
                   && (32'(in_item.requester) < 32'(REQUESTERS));
    assign in_addr  = AW'(32'(in_item.requester) * 32'(POOLS) + 32'(in_item.resource_kind));
    assign in_cap   = cap_of(in_pool, cap_reg);

    // Update step.
    assign is_alloc   = (op_reg == rqa_pkg::OP_ALLOC);
    assign is_release = (op_reg == rqa_pkg::OP_RELEASE);
    assign cap_cur    = cap_of(pool_reg, cap_reg);
    assign use_cur    = usage_reg[pool_reg];
    assign avail_cur  = (cap_cur > use_cur) ? cap_cur - use_cur : '0;
    assign alloc_full = (avail_cur >= amt_reg);
    assign alloc_ok   = alloc_full || (crit_reg && (avail_cur != '0));
    assign grant_amt  = alloc_full ? amt_reg : avail_cur;
    assign nu_wide    = {1'b0, use_cur} + {1'b0, grant_amt};
    assign nu_sat     = nu_wide[W] ? MAX32 : nu_wide[W-1:0];
    assign nh_wide    = {1'b0, held_rd_reg} + {1'b0, grant_amt};
    assign nh_sat     = nh_wide[W] ? MAX32 : nh_wide[W-1:0];
    assign rel_amt    = (amt_reg < held_rd_reg) ? amt_reg : held_rd_reg;
    assign use_rel    = (use_cur > rel_amt) ? use_cur - rel_amt : '0;
    assign held_new   = is_alloc ? nh_sat : held_rd_reg - rel_amt;

    assign mem_we    = cmd.clear
                    || (cmd.calc && inrange_reg && ((is_alloc && alloc_ok) || is_release));
    assign mem_waddr = cmd.clear ? clr_addr_reg : addr_reg;
    assign mem_wdata = cmd.clear ? '0 : held_new;

    assign stat.clear_last = (clr_addr_reg == AW'(DEPTH - 1));

    // Final step: alert evaluation, usage sum, peak and result.
    assign fin_use   = usage_reg[pool_reg];
    assign fin_cap   = cap_of(pool_reg, cap_reg);
    assign alert_new = eval_reg ? ({fin_use, 16'b0} > prod_reg) : alert_reg[pool_reg];
    assign sum_wide  = {1'b0, sum_reg[pool_reg]} + (SW + 1)'(fin_use);
    assign sum_new   = !stat_upd_reg ? sum_reg[pool_reg]
                     : (sum_wide[SW] ? MAX56 : sum_wide[SW-1:0]);
    assign peak_new  = (stat_upd_reg && (fin_use > peak_reg[pool_reg])) ? fin_use
                     : peak_reg[pool_reg];

    always_comb
    begin
        out_next = '0;
        out_next.rejected = rej_reg;
        if (inrange_reg)
        begin
            out_next.granted         = granted_reg;
            out_next.whole_grant     = full_reg;
            out_next.alert_flag      = alert_new;
            out_next.available_now   = (fin_cap > fin_use) ? fin_cap - fin_use : '0;
            out_next.usage_now       = fin_use;
            out_next.peak_seen       = peak_new;
            out_next.usage_total     = sum_new;
            out_next.samples_seen    = samples_reg[pool_reg];
            out_next.grants_seen     = grants_reg[pool_reg];
            out_next.refusals_seen   = refusals_reg[pool_reg];
        end
    end

    // Configuration, clearing counter and per-pool state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rqa_pkg::NUM_CAP_REGS; i++)
                cap_reg[i] <= rqa_pkg::CAP_RESET[i];
            thr_reg      <= rqa_pkg::THR_RESET;
            clr_addr_reg <= '0;
            for (int i = 0; i < POOLS; i++)
            begin
                usage_reg[i]    <= '0;
                peak_reg[i]     <= '0;
                sum_reg[i]      <= '0;
                samples_reg[i]  <= '0;
                grants_reg[i]   <= '0;
                refusals_reg[i] <= '0;
                alert_reg[i]    <= 1'b0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                if (32'(cfg_index) < 32'(rqa_pkg::NUM_CAP_REGS))
                    cap_reg[cfg_index] <= cfg_data[W-1:0];
                else if (cfg_index == rqa_pkg::CFG_THRESHOLD)
                    thr_reg <= cfg_data[rqa_pkg::THR_W-1:0];
            end
            if (cmd.clear && !stat.clear_last)
                clr_addr_reg <= clr_addr_reg + AW'(1);
            if (cmd.calc && inrange_reg)
            begin
                if (is_alloc)
                begin
                    if (alloc_ok)
                    begin
                        usage_reg[pool_reg] <= nu_sat;
                        if (samples_reg[pool_reg] != MAX32)
                            samples_reg[pool_reg] <= samples_reg[pool_reg] + W'(1);
                        if (grants_reg[pool_reg] != MAX32)
                            grants_reg[pool_reg] <= grants_reg[pool_reg] + W'(1);
                    end
                    else if (refusals_reg[pool_reg] != MAX32)
                        refusals_reg[pool_reg] <= refusals_reg[pool_reg] + W'(1);
                end
                else if (is_release)
                    usage_reg[pool_reg] <= use_rel;
            end
            if (cmd.fin && inrange_reg)
            begin
                alert_reg[pool_reg] <= alert_new;
                sum_reg[pool_reg]   <= sum_new;
                peak_reg[pool_reg]  <= peak_new;
            end
        end
    end

    // Item and step registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= in_item.op;
            pool_reg    <= in_pool;
            addr_reg    <= in_addr;
            amt_reg     <= in_item.request_amount;
            crit_reg    <= in_item.critical;
            inrange_reg <= in_range;
            prod_reg    <= PRW'(in_cap) * PRW'(thr_reg);
        end
        if (cmd.calc)
        begin
            granted_reg  <= '0;
            full_reg     <= 1'b0;
            stat_upd_reg <= 1'b0;
            eval_reg     <= 1'b0;
            rej_reg      <= is_alloc && !inrange_reg;
            if (inrange_reg)
            begin
                if (is_alloc)
                begin
                    granted_reg  <= alloc_ok ? grant_amt : '0;
                    full_reg     <= alloc_full;
                    rej_reg      <= !alloc_ok;
                    stat_upd_reg <= alloc_ok;
                    eval_reg     <= alloc_ok;
                end
                else if (is_release)
                begin
                    granted_reg <= rel_amt;
                    eval_reg    <= 1'b1;
                end
            end
        end
        if (cmd.fin)
            out_item <= out_next;
    end

    // Holdings memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            held_mem[mem_waddr] <= mem_wdata;
        if (cmd.load && in_range)
            held_rd_reg <= held_mem[in_addr];
    end

endmodule
`default_nettype wire

FILE: design/resource_quota_allocator_unit.sv
// Top level of the resource quota allocator.
// Depends on rqa_pkg, rqa_ctrl and rqa_dpath.
`default_nettype none
// The allocator keeps a capacity, a usage and a set of statistics for each
// pool, plus a holdings table with one entry per requester and pool. Each
// request transfer allocates, releases or queries, and gives exactly one
// result transfer carrying the pool's state after the request. A request
// passes through the capture step, which also reads the holdings memory,
// the update step, which applies the grant or release, and the final step,
// which evaluates the alert (usage * 65536 against threshold * capacity),
// folds the usage sum and peak, and loads the result register. The holdings
// memory's registered read sets that chain, so a request is taken only after
// the last one's final step; a finished result waiting in the output
// register does not hold off the next request, only its final step. After
// reset the holdings memory is swept to zero, all REQUESTERS * POOLS
// entries (320 by default), while input stays stalled; configuration writes
// are taken at any time and are meant to be made only while the block is idle.
module resource_quota_allocator_unit #(
    parameter int REQUESTERS = rqa_pkg::DEF_REQUESTERS,
    parameter int POOLS      = rqa_pkg::DEF_POOLS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [rqa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rqa_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire rqa_pkg::in_item_t              in_item,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output rqa_pkg::out_item_t                  out_item
);

    rqa_pkg::rqa_cmd_t  cmd;
    rqa_pkg::rqa_stat_t stat;

    // The controller sequences each transfer and owns the result valid.
    rqa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds all state and the result register.
    rqa_dpath #(
        .REQUESTERS (REQUESTERS),
        .POOLS      (POOLS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .out_item  (out_item),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
`default_nettype wire
